// ----- hw/rtl/ovn2d_pkg.sv -----
package ovn2d_pkg;

    typedef logic signed [31:0] t_coord;
    typedef logic signed [20:0] t_noise;
    typedef logic        [16:0] t_weight;
    typedef logic signed [17:0] t_smooth;
    typedef logic        [31:0] t_word;

    typedef enum logic {
        CFG_OCTAVE_COUNT = 1'b0,
        CFG_PERSISTENCE  = 1'b1
    } t_cfg_index;

    localparam logic [3:0]  OCT_RESET   = 4'd4;
    localparam logic [16:0] PERS_RESET  = 17'd32768;
    localparam logic [16:0] Q16_ONE     = 17'h10000;
    localparam t_word       HASH_MUL_Y  = 32'd57;
    localparam t_word       HASH_MUL_A  = 32'd15731;
    localparam t_word       HASH_ADD_A  = 32'd789221;
    localparam t_word       HASH_ADD_B  = 32'd1376312589;
    localparam int          OUT_MAX     = 589824;
    localparam int          OUT_MIN     = -589824;

    function automatic t_weight cos_entry(input int unsigned k, input int unsigned cos_bits);
        longint unsigned phi;
        longint unsigned p2;
        longint unsigned t;
        longint unsigned s;
        phi = (64'd3373259426 * longint'(k)) >> (cos_bits + 1);
        p2  = (phi * phi) >> 30;
        t   = 64'd1073741824;
        t   = t - ((p2 * t) >> 30) / 110;
        t   = t - ((p2 * t) >> 30) / 72;
        t   = t - ((p2 * t) >> 30) / 42;
        t   = t - ((p2 * t) >> 30) / 20;
        t   = t - ((p2 * t) >> 30) / 6;
        s   = (phi * t) >> 30;
        return t_weight'((s * s + (64'd1 << 43)) >> 44);
    endfunction

    function automatic t_smooth blend(input t_smooth a, input t_smooth b, input t_weight f);
        logic signed [36:0] s;
        s = 37'(a) * 37'(signed'({1'b0, t_weight'(Q16_ONE - f)}))
          + 37'(b) * 37'(signed'({1'b0, f}));
        return t_smooth'(s >>> 16);
    endfunction

endpackage

// ----- hw/rtl/octave_value_noise_2d_unit.sv -----
// Summed 2-D value noise. Each coordinate pair enters through the input
// channel and occupies the octave issue stage until all its octaves are
// issued (1 to 8 octaves at the defaults): one octave of sixteen lattice
// hashes, smoothing, cosine blending and amplitude scaling enters the
// ten-stage pipeline per cycle while the output is not stalled, and the next
// pair is taken only as the last octave issues. Octave results are summed at
// the pipeline end and one saturated Q.16 value leaves per item. Write the
// registers only while the block is idle.
module octave_value_noise_2d_unit #(
    parameter int MAX_OCTAVES = 8,
    parameter int COS_BITS    = 10,
    parameter int FRAC_BITS   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ovn2d_pkg::t_coord i_x_coord,
    input  ovn2d_pkg::t_coord i_y_coord,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ovn2d_pkg::t_noise o_noise_value,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [16:0]       i_cfg_data
);
    import ovn2d_pkg::*;

    localparam int OW   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int SW   = FRAC_BITS + 32;
    localparam int NCOS = 2 ** COS_BITS;
    localparam int AW   = 24;

    logic [3:0]  r_cfg_count;
    logic [16:0] r_cfg_pers;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= OCT_RESET;
            r_cfg_pers  <= PERS_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_OCTAVE_COUNT: r_cfg_count <= i_cfg_data[3:0];
                CFG_PERSISTENCE:  r_cfg_pers  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_weight w_cos [NCOS];
    for (genvar g = 0; g < NCOS; g++) begin : g_cos
        assign w_cos[g] = cos_entry(g, COS_BITS);
    end

    logic en;
    assign en = !(o_out_valid && i_out_stall);

    // octave issue stage
    logic          r_busy;
    logic [OW-1:0] r_oct;
    logic [OW-1:0] r_last;
    logic [31:0]   r_mag_x, r_mag_y;
    logic          r_neg_x, r_neg_y;
    logic [16:0]   r_amp;
    logic          oct_done, in_acc;
    logic [16:0]   pers;
    logic [33:0]   amp_prod;
    logic [OW-1:0] n_last;

    assign oct_done   = !r_busy || (r_oct == r_last);
    assign o_in_stall = !(en && oct_done);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign pers       = (r_cfg_pers > Q16_ONE) ? Q16_ONE : r_cfg_pers;
    assign amp_prod   = 34'(r_amp) * 34'(pers);

    always_comb begin
        if (r_cfg_count == 4'd0) begin
            n_last = '0;
        end else if (5'(r_cfg_count) > 5'(MAX_OCTAVES)) begin
            n_last = OW'(MAX_OCTAVES - 1);
        end else begin
            n_last = OW'(r_cfg_count - 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (en) begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (oct_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (in_acc) begin
                r_oct   <= '0;
                r_last  <= n_last;
                r_amp   <= Q16_ONE;
                r_neg_x <= i_x_coord[31];
                r_neg_y <= i_y_coord[31];
                r_mag_x <= i_x_coord[31] ? 32'(-i_x_coord) : 32'(i_x_coord);
                r_mag_y <= i_y_coord[31] ? 32'(-i_y_coord) : 32'(i_y_coord);
            end else if (!oct_done) begin
                r_oct <= r_oct + OW'(1);
                r_amp <= amp_prod[32:16];
            end
        end
    end

    // valid and flags for each stage
    localparam int NS = 9;
    logic        r_v     [NS];
    logic        r_first [NS];
    logic        r_lst   [NS];
    logic [16:0] r_amps  [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_v[s] <= 1'b0;
        end else if (en) begin
            r_v[0] <= r_busy;
            for (int s = 1; s < NS; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_first[0] <= (r_oct == '0);
            r_lst[0]   <= (r_oct == r_last);
            r_amps[0]  <= r_amp;
            for (int s = 1; s < NS; s++) begin
                r_first[s] <= r_first[s-1];
                r_lst[s]   <= r_lst[s-1];
                r_amps[s]  <= r_amps[s-1];
            end
        end
    end

    // stage 1: scale and split
    logic [SW-1:0]       shx, shy;
    logic [31:0]         ipx, ipy;
    logic [COS_BITS-1:0] idxx, idxy;
    logic [31:0]         r_s1_ix, r_s1_iy;
    logic [COS_BITS-1:0] r_s1_idxx, r_s1_idxy;

    assign shx = SW'(r_mag_x) << r_oct;
    assign shy = SW'(r_mag_y) << r_oct;
    assign ipx = shx[SW-1:FRAC_BITS];
    assign ipy = shy[SW-1:FRAC_BITS];

    if (FRAC_BITS >= COS_BITS) begin : g_idx_hi
        assign idxx = shx[FRAC_BITS-1 -: COS_BITS];
        assign idxy = shy[FRAC_BITS-1 -: COS_BITS];
    end else begin : g_idx_lo
        assign idxx = COS_BITS'(shx[FRAC_BITS-1:0]) << (COS_BITS - FRAC_BITS);
        assign idxy = COS_BITS'(shy[FRAC_BITS-1:0]) << (COS_BITS - FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ix   <= r_neg_x ? -ipx : ipx;
            r_s1_iy   <= r_neg_y ? -ipy : ipy;
            r_s1_idxx <= idxx;
            r_s1_idxy <= idxy;
        end
    end

    // stages 2 to 5: sixteen lattice hashes, weights carried alongside
    t_word   r_s2_n [16];
    t_word   r_s3_n [16], r_s3_sq [16];
    t_word   r_s4_n [16], r_s4_t  [16];
    t_smooth r_s5_h [16];
    t_weight r_wx [4:2], r_wy [4:2];
    t_word   n_n  [16];
    t_word   n_u  [16];

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            n_n[k] = (r_s1_ix + 32'(k % 4) - 32'd1)
                   + (r_s1_iy + 32'(k / 4) - 32'd1) * HASH_MUL_Y;
            n_n[k] = (n_n[k] << 13) ^ n_n[k];
            n_u[k] = r_s4_n[k] * r_s4_t[k] + HASH_ADD_B;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx[2] <= w_cos[r_s1_idxx];
            r_wy[2] <= w_cos[r_s1_idxy];
            r_wx[3] <= r_wx[2];
            r_wy[3] <= r_wy[2];
            r_wx[4] <= r_wx[3];
            r_wy[4] <= r_wy[3];
            for (int k = 0; k < 16; k++) begin
                r_s2_n[k]  <= n_n[k];
                r_s3_n[k]  <= r_s2_n[k];
                r_s3_sq[k] <= r_s2_n[k] * r_s2_n[k];
                r_s4_n[k]  <= r_s3_n[k];
                r_s4_t[k]  <= r_s3_sq[k] * HASH_MUL_A + HASH_ADD_A;
                r_s5_h[k]  <= t_smooth'(18'sd65536 - t_smooth'({1'b0, n_u[k][30:14]}));
            end
        end
    end

    // stage 6: smoothing of the four cell corners
    t_weight r_s5_wx, r_s5_wy, r_s6_wx, r_s6_wy, r_s7_wy;
    t_smooth r_s6_c [4];
    logic signed [22:0] sm_sum [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            sm_sum[c] = '0;
            for (int ey = 0; ey < 3; ey++) begin
                for (int ex = 0; ex < 3; ex++) begin
                    sm_sum[c] = sm_sum[c]
                        + (23'(r_s5_h[(c / 2 + ey) * 4 + (c % 2 + ex)])
                           <<< ((ex == 1 ? 1 : 0) + (ey == 1 ? 1 : 0)));
                end
            end
        end
    end

    // stages 7 to 9: blend along x, along y, scale by amplitude
    t_smooth r_s7_a, r_s7_b, r_s8_v;
    logic signed [AW-1:0] r_s9_term;
    logic signed [35:0]   term_prod;

    assign term_prod = 36'(r_s8_v) * 36'(signed'({1'b0, r_amps[7]}));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_wx <= r_wx[4];
            r_s5_wy <= r_wy[4];
            r_s6_wx <= r_s5_wx;
            r_s6_wy <= r_s5_wy;
            for (int c = 0; c < 4; c++) r_s6_c[c] <= t_smooth'(sm_sum[c] >>> 4);
            r_s7_a    <= blend(r_s6_c[0], r_s6_c[1], r_s6_wx);
            r_s7_b    <= blend(r_s6_c[2], r_s6_c[3], r_s6_wx);
            r_s7_wy   <= r_s6_wy;
            r_s8_v    <= blend(r_s7_a, r_s7_b, r_s7_wy);
            r_s9_term <= AW'(term_prod >>> 16);
        end
    end

    // accumulate octaves, saturate, hold for the output transaction
    logic signed [AW-1:0] r_acc, n_acc;
    t_noise               r_out;
    logic                 r_out_valid;

    assign n_acc = r_first[8] ? r_s9_term : r_acc + r_s9_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v[8] && r_lst[8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v[8]) begin
            r_acc <= n_acc;
            if (n_acc > AW'(OUT_MAX)) begin
                r_out <= t_noise'(OUT_MAX);
            end else if (n_acc < AW'(OUT_MIN)) begin
                r_out <= t_noise'(OUT_MIN);
            end else begin
                r_out <= t_noise'(n_acc);
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_out;

endmodule

// ----- hw/rtl/ovn2d_checker.sv -----
module ovn2d_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input ovn2d_pkg::t_noise o_noise_value,
    input logic              o_cfg_ready
);
    import ovn2d_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_noise_value))
        else $error("output changed while stalled");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_noise_value <= 21'(OUT_MAX)) && (o_noise_value >= 21'(OUT_MIN)))
        else $error("noise value out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while output blocked");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind octave_value_noise_2d_unit ovn2d_checker u_ovn2d_checker (.*);
